### hdl/mmb_pkg.sv
// ----------------------------------------------------------------------------
// Member mailbox package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mmb_pkg;

	localparam int PID_W     = 16;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int VALUE_W   = 7;
	localparam int WORD_W    = 64;

	localparam int IN_CALLER_LSB = 0;
	localparam int IN_PEER_LSB   = PID_W;
	localparam int IN_WORD_LSB   = 2 * PID_W;
	localparam int IN_DATA_W     = 96;
	localparam int IN_USER_W     = 4;
	localparam int IN_BCAST_BIT  = MODE_W;
	localparam int OUT_USED_W    = STATUS_W + VALUE_W + PID_W + WORD_W;
	localparam int OUT_DATA_W    = 96;

	localparam int DEF_MEMBER_SLOTS = 8;
	localparam int DEF_STORE_DEPTH  = 64;
	localparam int DEF_PID_BITS     = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE = 3'd0,
		MODE_SEND   = 3'd1,
		MODE_RECV   = 3'd2,
		MODE_BLOCK  = 3'd3,
		MODE_JOIN   = 3'd4,
		MODE_LEAVE  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_EXEC,
		S_BC_COUNT,
		S_BC_CHECK,
		S_BC_SEND,
		S_RX_SCAN,
		S_RX_SHIFT,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic    take_in;
		logic    find;
		logic    do_create;
		logic    do_direct;
		logic    do_block;
		logic    do_join;
		logic    do_leave;
		logic    bc_start;
		logic    bc_count;
		logic    bc_rewind;
		logic    bc_send;
		logic    scan_start;
		logic    scan_step;
		logic    shift_step;
		logic    shift_done;
		logic    set_status;
		status_t code;
		logic    load_out;
	} mmb_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              bcast;
		logic              me_ok;
		logic              other_ok;
		logic              direct_blocked;
		logic              store_full;
		logic              bc_fits;
		logic              total_zero;
		logic              total_full;
		logic              walk_last;
		logic              scan_hit;
		logic              scan_end;
		logic              shift_end;
		logic              out_free;
	} mmb_sts_t;

endpackage

### hdl/mmb_ctrl.sv
// ----------------------------------------------------------------------------
// Member mailbox controller
// Sequences each request through search, dispatch, walks and result hand-off.
// ----------------------------------------------------------------------------
module mmb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  mmb_pkg::mmb_sts_t sts,
	output mmb_pkg::mmb_cmd_t cmd
);
	import mmb_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.code  = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_nxt   = S_FIND;
				end
			end
			S_FIND: begin
				cmd.find  = 1'b1;
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_DONE;
				case (sts.mode)
					MODE_CREATE: begin
						cmd.do_create = 1'b1;
					end
					MODE_SEND: begin
						if (!sts.me_ok) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else if (sts.bcast) begin
							cmd.bc_start = 1'b1;
							state_nxt    = S_BC_COUNT;
						end else if (!sts.other_ok || sts.direct_blocked) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else if (sts.store_full) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_FULL;
						end else begin
							cmd.do_direct = 1'b1;
						end
					end
					MODE_RECV: begin
						if (!sts.me_ok) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else begin
							cmd.scan_start = 1'b1;
							state_nxt      = S_RX_SCAN;
						end
					end
					MODE_BLOCK: begin
						if (!sts.me_ok || !sts.other_ok) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else begin
							cmd.do_block = 1'b1;
						end
					end
					MODE_JOIN: begin
						if (sts.total_zero) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else if (sts.total_full) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_FULL;
						end else begin
							cmd.do_join = 1'b1;
						end
					end
					MODE_LEAVE: begin
						if (!sts.me_ok) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
						end else begin
							cmd.do_leave = 1'b1;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.code       = ST_INVALID;
					end
				endcase
			end
			S_BC_COUNT: begin
				cmd.bc_count = 1'b1;
				if (sts.walk_last) begin
					state_nxt = S_BC_CHECK;
				end
			end
			S_BC_CHECK: begin
				if (sts.bc_fits) begin
					cmd.bc_rewind = 1'b1;
					state_nxt     = S_BC_SEND;
				end else begin
					cmd.set_status = 1'b1;
					cmd.code       = ST_FULL;
					state_nxt      = S_DONE;
				end
			end
			S_BC_SEND: begin
				cmd.bc_send = 1'b1;
				if (sts.walk_last) begin
					state_nxt = S_DONE;
				end
			end
			S_RX_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) begin
					state_nxt = S_RX_SHIFT;
				end else if (sts.scan_end) begin
					state_nxt = S_DONE;
				end
			end
			S_RX_SHIFT: begin
				if (sts.shift_end) begin
					cmd.shift_done = 1'b1;
					state_nxt      = S_DONE;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/mmb_datapath.sv
// ----------------------------------------------------------------------------
// Member mailbox datapath
// Member list, block matrix, message store memory and result registers.
// ----------------------------------------------------------------------------
module mmb_datapath #(
	parameter int MEMBER_SLOTS = mmb_pkg::DEF_MEMBER_SLOTS,
	parameter int STORE_DEPTH  = mmb_pkg::DEF_STORE_DEPTH,
	parameter int PID_BITS     = mmb_pkg::DEF_PID_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mmb_pkg::mmb_cmd_t              cmd,
	output mmb_pkg::mmb_sts_t              sts,
	input  logic [mmb_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [mmb_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mmb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import mmb_pkg::*;

	localparam int PW = (PID_BITS < PID_W) ? PID_BITS : PID_W;
	localparam int IW = $clog2(MEMBER_SLOTS);
	localparam int TW = $clog2(MEMBER_SLOTS + 1);
	localparam int NW = $clog2(MEMBER_SLOTS + 1);
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int FW = $clog2(STORE_DEPTH + 1);
	localparam int SW = ((FW > NW) ? FW : NW) + 1;

	// Request registers
	logic [MODE_W-1:0] mode_q;
	logic              bcast_q;
	logic [PW-1:0]     caller_q;
	logic [PW-1:0]     peer_q;
	logic [WORD_W-1:0] word_q;

	// Members and block matrix
	logic [PW-1:0]           ids_q  [MEMBER_SLOTS];
	logic [MEMBER_SLOTS-1:0] rows_q [MEMBER_SLOTS];
	logic [MEMBER_SLOTS-1:0] sq_rows[MEMBER_SLOTS];
	logic [TW-1:0]           total_q;
	logic [IW-1:0]           me_q;
	logic [IW-1:0]           other_q;
	logic                    me_ok_q;
	logic                    other_ok_q;
	logic [IW-1:0]           me_f;
	logic [IW-1:0]           other_f;
	logic                    me_hit;
	logic                    other_hit;
	logic [MEMBER_SLOTS-1:0] row_me;
	logic [MEMBER_SLOTS-1:0] low_mask;

	// Broadcast walk
	logic [IW-1:0] idx_q;
	logic [NW-1:0] n_q;
	logic          elig;
	logic          walk_last;

	// Store memory and its walks
	logic [PW-1:0]     mem_snd [STORE_DEPTH];
	logic [PW-1:0]     mem_rcv [STORE_DEPTH];
	logic [WORD_W-1:0] mem_word[STORE_DEPTH];
	logic [PW-1:0]     rd_snd;
	logic [PW-1:0]     rd_rcv;
	logic [WORD_W-1:0] rd_word;
	logic [AW-1:0]     rd_addr;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     scan_q;
	logic              chk_v_q;
	logic [AW-1:0]     chk_idx_q;
	logic [FW-1:0]     sh_q;
	logic [FW-1:0]     sh_nxt;
	logic              wv_q;
	logic [AW-1:0]     wa_q;
	logic              app_we;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [PW-1:0]     wr_snd;
	logic [PW-1:0]     wr_rcv;
	logic [WORD_W-1:0] wr_word;
	logic              scan_hit;

	// Result and output registers
	status_t           status_q;
	logic [VALUE_W-1:0] value_q;
	logic [PW-1:0]     sender_q;
	logic [WORD_W-1:0] msg_q;
	logic              out_v_q;
	status_t           out_status_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [PW-1:0]     out_sender_q;
	logic [WORD_W-1:0] out_msg_q;

	// First matching slot below the member count, for caller and peer.
	always_comb begin
		me_f      = '0;
		me_hit    = 1'b0;
		other_f   = '0;
		other_hit = 1'b0;
		for (int i = MEMBER_SLOTS - 1; i >= 0; i--) begin
			if (TW'(i) < total_q && ids_q[i] == caller_q) begin
				me_hit = 1'b1;
				me_f   = IW'(i);
			end
			if (TW'(i) < total_q && ids_q[i] == peer_q) begin
				other_hit = 1'b1;
				other_f   = IW'(i);
			end
		end
	end

	// Each row with the leaving member's column squeezed out.
	assign low_mask = (MEMBER_SLOTS'(1) << me_q) - MEMBER_SLOTS'(1);
	always_comb begin
		for (int i = 0; i < MEMBER_SLOTS; i++) begin
			sq_rows[i] = (rows_q[i] & low_mask) | ((rows_q[i] >> 1) & ~low_mask);
		end
	end

	assign row_me    = rows_q[me_q];
	assign elig      = (ids_q[idx_q] != caller_q) && !row_me[idx_q];
	assign walk_last = (TW'(idx_q) + TW'(1)) == total_q;

	assign sh_nxt   = sh_q + FW'(1);
	assign rd_addr  = cmd.shift_step ? sh_nxt[AW-1:0] : scan_q[AW-1:0];
	assign scan_hit = chk_v_q && (rd_rcv == caller_q);

	assign app_we  = cmd.do_direct || (cmd.bc_send && elig);
	assign mem_we  = app_we || wv_q;
	assign mem_wa  = wv_q ? wa_q : fill_q[AW-1:0];
	assign wr_snd  = wv_q ? rd_snd : caller_q;
	assign wr_rcv  = wv_q ? rd_rcv : (cmd.bc_send ? ids_q[idx_q] : peer_q);
	assign wr_word = wv_q ? rd_word : word_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_snd[mem_wa]  <= wr_snd;
			mem_rcv[mem_wa]  <= wr_rcv;
			mem_word[mem_wa] <= wr_word;
		end
		rd_snd  <= mem_snd[rd_addr];
		rd_rcv  <= mem_rcv[rd_addr];
		rd_word <= mem_word[rd_addr];
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			mode_q   <= s_tuser[MODE_W-1:0];
			bcast_q  <= s_tuser[IN_BCAST_BIT];
			caller_q <= s_tdata[IN_CALLER_LSB +: PW];
			peer_q   <= s_tdata[IN_PEER_LSB +: PW];
			word_q   <= s_tdata[IN_WORD_LSB +: WORD_W];
			sender_q <= '0;
			msg_q    <= '0;
		end
		if (cmd.find) begin
			me_q    <= me_f;
			other_q <= other_f;
		end
		if (cmd.scan_step && scan_hit) begin
			sender_q <= rd_snd;
			msg_q    <= rd_word;
		end
		if (cmd.do_create) begin
			ids_q[0] <= caller_q;
		end
		if (cmd.do_join) begin
			ids_q[total_q[IW-1:0]] <= caller_q;
		end
		if (cmd.do_leave) begin
			for (int i = 0; i < MEMBER_SLOTS; i++) begin
				if (i == MEMBER_SLOTS - 1) begin
					ids_q[i] <= '0;
				end else if (IW'(i) >= me_q) begin
					ids_q[i] <= ids_q[i + 1];
				end
			end
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			out_value_q  <= value_q;
			out_sender_q <= sender_q;
			out_msg_q    <= msg_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= '0;
			fill_q     <= '0;
			me_ok_q    <= 1'b0;
			other_ok_q <= 1'b0;
			idx_q      <= '0;
			n_q        <= '0;
			scan_q     <= '0;
			chk_v_q    <= 1'b0;
			chk_idx_q  <= '0;
			sh_q       <= '0;
			wv_q       <= 1'b0;
			wa_q       <= '0;
			status_q   <= ST_OK;
			value_q    <= '0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < MEMBER_SLOTS; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			if (cmd.take_in) begin
				status_q <= ST_OK;
				value_q  <= '0;
				wv_q     <= 1'b0;
			end
			if (cmd.find) begin
				me_ok_q    <= me_hit;
				other_ok_q <= other_hit;
			end
			if (cmd.set_status) begin
				status_q <= cmd.code;
			end
			if (cmd.do_create) begin
				total_q <= TW'(1);
				fill_q  <= '0;
				for (int i = 0; i < MEMBER_SLOTS; i++) begin
					rows_q[i] <= '0;
				end
			end
			if (app_we) begin
				fill_q <= fill_q + FW'(1);
			end
			if (cmd.do_direct) begin
				value_q <= VALUE_W'(1);
			end
			if (cmd.do_block) begin
				rows_q[other_q][me_q] <= 1'b1;
			end
			if (cmd.do_join) begin
				for (int i = 0; i < MEMBER_SLOTS; i++) begin
					if (TW'(i) == total_q) begin
						rows_q[i] <= '0;
					end else begin
						rows_q[i] <= rows_q[i] & ~(MEMBER_SLOTS'(1) << total_q[IW-1:0]);
					end
				end
				total_q <= total_q + TW'(1);
			end
			if (cmd.do_leave) begin
				for (int i = 0; i < MEMBER_SLOTS; i++) begin
					if (total_q == TW'(1) || i == MEMBER_SLOTS - 1) begin
						rows_q[i] <= '0;
					end else if (IW'(i) >= me_q) begin
						rows_q[i] <= sq_rows[i + 1];
					end else begin
						rows_q[i] <= sq_rows[i];
					end
				end
				if (total_q == TW'(1)) begin
					fill_q <= '0;
				end
				total_q <= total_q - TW'(1);
			end
			if (cmd.bc_start) begin
				idx_q <= '0;
				n_q   <= '0;
			end
			if (cmd.bc_count) begin
				n_q   <= n_q + NW'(elig);
				idx_q <= walk_last ? '0 : idx_q + IW'(1);
			end
			if (cmd.bc_rewind) begin
				idx_q   <= '0;
				value_q <= VALUE_W'(n_q);
			end
			if (cmd.bc_send) begin
				idx_q <= walk_last ? '0 : idx_q + IW'(1);
			end
			if (cmd.scan_start) begin
				scan_q  <= '0;
				chk_v_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (scan_q < fill_q) begin
					chk_v_q   <= 1'b1;
					chk_idx_q <= scan_q[AW-1:0];
					scan_q    <= scan_q + FW'(1);
				end else begin
					chk_v_q <= 1'b0;
				end
				if (scan_hit) begin
					value_q <= VALUE_W'(1);
					sh_q    <= FW'(chk_idx_q);
					wv_q    <= 1'b0;
				end
			end
			if (cmd.shift_step) begin
				if (sh_nxt < fill_q) begin
					wv_q <= 1'b1;
					wa_q <= sh_q[AW-1:0];
					sh_q <= sh_nxt;
				end else begin
					wv_q <= 1'b0;
				end
			end
			if (cmd.shift_done) begin
				fill_q <= fill_q - FW'(1);
			end
			if (cmd.load_out) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign sts.mode           = mode_q;
	assign sts.bcast          = bcast_q;
	assign sts.me_ok          = me_ok_q;
	assign sts.other_ok       = other_ok_q;
	assign sts.direct_blocked = row_me[other_q];
	assign sts.store_full     = (fill_q == FW'(STORE_DEPTH));
	assign sts.bc_fits        = (SW'(fill_q) + SW'(n_q)) <= SW'(STORE_DEPTH);
	assign sts.total_zero     = (total_q == '0);
	assign sts.total_full     = (total_q >= TW'(MEMBER_SLOTS));
	assign sts.walk_last      = walk_last;
	assign sts.scan_hit       = scan_hit;
	assign sts.scan_end       = !chk_v_q && (scan_q >= fill_q);
	assign sts.shift_end      = !wv_q && (sh_nxt >= fill_q);
	assign sts.out_free       = !out_v_q || m_tready;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_msg_q, PID_W'(out_sender_q),
		out_value_q, out_status_q};

endmodule

### hdl/member_mailbox_with_block_matrix_core.sv
// ----------------------------------------------------------------------------
// Member mailbox with block matrix
// Top level: request stream in, one result transfer out for every request.
// ----------------------------------------------------------------------------
// Each request transfer carries one mailbox operation (create, send, receive,
// block, join or leave) and produces exactly one result transfer. Requests
// are processed one at a time by a controller and a datapath. Create, block,
// join, leave, direct send and every request rejected at dispatch pass from
// acceptance through search and dispatch straight to the result. A broadcast
// send walks the member list twice, once to count the eligible receivers and
// once to append their messages, or only once when the store cannot take all
// of them. A receive scans the message store one entry per cycle through its
// single read port until it finds the caller's oldest message, then closes
// the gap by moving each later entry down one place per cycle. The result
// sits in an output register, and a new request is accepted in the cycle
// after the previous result has been loaded into it; while the receiver
// still holds an earlier result, the finished request waits and the input
// stalls.
// Member ids are compared on their low PID_BITS bits (at most 16).
module member_mailbox_with_block_matrix_core #(
	parameter int MEMBER_SLOTS = mmb_pkg::DEF_MEMBER_SLOTS,
	parameter int STORE_DEPTH  = mmb_pkg::DEF_STORE_DEPTH,
	parameter int PID_BITS     = mmb_pkg::DEF_PID_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// caller_pid [15:0], peer_pid [31:16], payload [95:32]
	input  logic [mmb_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode [2:0], broadcast [3]
	input  logic [mmb_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status [1:0], result_value [8:2], sender_pid [24:9], message_word [88:25],
	// zero fill [95:89]
	output logic [mmb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import mmb_pkg::*;

	// Commands from the controller and status back from the datapath.
	mmb_cmd_t cmd;
	mmb_sts_t sts;

	mmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the member list, the block matrix, the message store
	// and the output register.
	mmb_datapath #(
		.MEMBER_SLOTS (MEMBER_SLOTS),
		.STORE_DEPTH  (STORE_DEPTH),
		.PID_BITS     (PID_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
